FILE: rtl/pmmf_pkg.sv
// shared types, constants and the 2^(i/16) table for the max-pool mean-field block
package pmmf_pkg;

  localparam int unsigned MAX_SIDE = 32;
  localparam int unsigned MAX_POOL = 8;
  localparam int unsigned CELLS    = MAX_SIDE * MAX_SIDE;
  localparam int unsigned ADDR_W   = $clog2(CELLS);
  localparam int unsigned SIDE_W   = 6;
  localparam int unsigned POOL_W   = 4;
  localparam int unsigned ITER_W   = 5;
  localparam int unsigned LCNT_W   = 11;
  localparam int unsigned RCNT_W   = 12;
  localparam int unsigned DEN_W    = 40;
  localparam int unsigned NUM_W    = 48;
  localparam int unsigned PADDR_W  = 4;

  typedef enum logic [1:0] {
    REG_SIDE  = 2'd0,
    REG_POOL  = 2'd1,
    REG_ITERS = 2'd2,
    REG_EMIT  = 2'd3
  } reg_idx_e;

  typedef enum logic [4:0] {
    S_LOAD,
    S_PREP,
    S_EXP_RD,
    S_EXP_MUL,
    S_EXP_INT,
    S_EXP_WR,
    S_SUM_RD,
    S_SUM_ACC,
    S_DIV_RD,
    S_DIV_ST,
    S_DIV_RUN,
    S_DIV_WR,
    S_OFF_ST,
    S_OFF_RUN,
    S_OFF_WR,
    S_READ,
    S_RD_OUT
  } state_e;

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_READ = 1'b1;

  typedef struct packed {
    logic               command;
    logic signed [15:0] activation;
  } pmmf_in_t;

  typedef struct packed {
    logic [15:0] value;
    logic        is_pool;
    logic        last;
  } pmmf_out_t;

  // 2^(i/16) in q2.16
  function automatic logic [17:0] pow2_lut(input logic [4:0] idx);
    logic [17:0] r;
    case (idx)
      5'd0:    r = 18'd65536;
      5'd1:    r = 18'd68438;
      5'd2:    r = 18'd71468;
      5'd3:    r = 18'd74632;
      5'd4:    r = 18'd77936;
      5'd5:    r = 18'd81386;
      5'd6:    r = 18'd84990;
      5'd7:    r = 18'd88752;
      5'd8:    r = 18'd92682;
      5'd9:    r = 18'd96785;
      5'd10:   r = 18'd101070;
      5'd11:   r = 18'd105545;
      5'd12:   r = 18'd110218;
      5'd13:   r = 18'd115098;
      5'd14:   r = 18'd120194;
      5'd15:   r = 18'd125515;
      5'd16:   r = 18'd131072;
      default: r = 18'd131072;
    endcase
    return r;
  endfunction

endpackage

FILE: rtl/pmmf_exp.sv
// fixed-point exp unit, q16.16 in and out, saturating
module pmmf_exp (
  input  logic               clk_i,
  input  logic signed [32:0] x_i,
  output logic [31:0]        y_o
);
  import pmmf_pkg::*;

  localparam logic signed [17:0] LOG2E = 18'sd94548;

  logic signed [50:0] prod_q;
  logic signed [34:0] y;
  logic signed [18:0] k;
  logic [15:0]        f;
  logic [17:0]        t_lo, t_hi;
  logic [24:0]        interp;
  logic [16:0]        m_d, m_q;
  logic               sat_d, sat_q, zero_d, zero_q, left_d, left_q;
  logic [4:0]         sh_d, sh_q;
  logic signed [18:0] neg_k;

  always_ff @(posedge clk_i) begin
    prod_q <= x_i * LOG2E;
    m_q    <= m_d;
    sat_q  <= sat_d;
    zero_q <= zero_d;
    left_q <= left_d;
    sh_q   <= sh_d;
  end

  always_comb begin
    y      = 35'(prod_q >>> 16);
    k      = 19'(y >>> 16);
    f      = y[15:0];
    t_lo   = pow2_lut({1'b0, f[15:12]});
    t_hi   = pow2_lut(5'({1'b0, f[15:12]} + 5'd1));
    interp = 25'((t_hi - t_lo) * {13'd0, f[11:0]});
    m_d    = 17'(t_lo + {11'd0, interp[24:12]});
    neg_k  = -k;
    sat_d  = (k >= 19'sd16);
    zero_d = (k <= -19'sd32);
    left_d = (k >= 19'sd0);
    sh_d   = left_d ? k[4:0] : neg_k[4:0];
  end

  always_comb begin
    if (sat_q) begin
      y_o = 32'hFFFF_FFFF;
    end else if (zero_q) begin
      y_o = 32'd0;
    end else if (left_q) begin
      y_o = {15'd0, m_q} << sh_q;
    end else begin
      y_o = {15'd0, m_q} >> sh_q;
    end
  end

endmodule

FILE: rtl/pmmf_div.sv
// restoring divider, one quotient bit per cycle
module pmmf_div (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [pmmf_pkg::NUM_W-1:0] num_i,
  input  logic [pmmf_pkg::DEN_W-1:0] den_i,
  output logic                       done_o,
  output logic [pmmf_pkg::NUM_W-1:0] quo_o
);
  import pmmf_pkg::*;

  localparam int unsigned CNT_W = $clog2(NUM_W + 1);

  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             run_q, run_d, done_q, done_d;
  logic [DEN_W:0]   rem_q, rem_d, rem_sh;
  logic [NUM_W-1:0] quo_q, quo_d;
  logic [DEN_W-1:0] den_q, den_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      run_q  <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      run_q  <= run_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    den_q <= den_d;
  end

  always_comb begin
    cnt_d  = cnt_q;
    run_d  = run_q;
    done_d = 1'b0;
    rem_d  = rem_q;
    quo_d  = quo_q;
    den_d  = den_q;
    rem_sh = {rem_q[DEN_W-1:0], quo_q[NUM_W-1]};
    if (start_i) begin
      rem_d = '0;
      quo_d = num_i;
      den_d = den_i;
      cnt_d = CNT_W'(NUM_W);
      run_d = 1'b1;
    end else if (run_q) begin
      if (rem_sh >= {1'b0, den_q}) begin
        rem_d = rem_sh - {1'b0, den_q};
        quo_d = {quo_q[NUM_W-2:0], 1'b1};
      end else begin
        rem_d = rem_sh;
        quo_d = {quo_q[NUM_W-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CNT_W'(1)) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

FILE: rtl/prob_max_pool_mean_field_top.sv
// top level: register port, sequencer, cell stores, exp and divide units
//
//  channel  | ports                              | transaction
//  ---------+------------------------------------+-----------------------------------
//  command  | start, busy, cmd_i                 | start high while busy low
//  result   | result_valid_o, result_o           | one-cycle strobe, no back-pressure
//  config   | psel, penable, pwrite, paddr, ...  | access phase with pready high
//
//  each load writes one cell; the load that fills the grid starts the run
//  a run does, on every iteration, an exp per cell, a block-sum read and a 48-step
//  divide per pooled cell, and on the last iteration one off-probability divide per block
//  a read goes through S_READ (address, busy low) then S_RD_OUT (result strobe, busy high)
//  reset clears control state and registers; cell stores hold garbage until loaded
//  the result side cannot stall, results appear only in answer to a read command
module prob_max_pool_mean_field_top (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start,
  output logic                         busy,
  input  pmmf_pkg::pmmf_in_t           cmd_i,
  output logic                         result_valid_o,
  output pmmf_pkg::pmmf_out_t          result_o,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [pmmf_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);
  import pmmf_pkg::*;

  // configuration registers
  logic [SIDE_W-1:0] cfg_side_q;
  logic [POOL_W-1:0] cfg_pool_q;
  logic [ITER_W-1:0] cfg_iters_q;
  logic              cfg_emit_q;
  logic              cfg_we;
  reg_idx_e          cfg_idx;

  assign pready  = 1'b1;
  assign cfg_we  = psel && penable && pwrite;
  assign cfg_idx = reg_idx_e'(paddr[3:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_side_q  <= SIDE_W'(32);
      cfg_pool_q  <= POOL_W'(2);
      cfg_iters_q <= ITER_W'(1);
      cfg_emit_q  <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_SIDE:  cfg_side_q  <= pwdata[SIDE_W-1:0];
        REG_POOL:  cfg_pool_q  <= pwdata[POOL_W-1:0];
        REG_ITERS: cfg_iters_q <= pwdata[ITER_W-1:0];
        REG_EMIT:  cfg_emit_q  <= pwdata[0];
        default:   ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_SIDE:  prdata = {26'd0, cfg_side_q};
      REG_POOL:  prdata = {28'd0, cfg_pool_q};
      REG_ITERS: prdata = {27'd0, cfg_iters_q};
      REG_EMIT:  prdata = {31'd0, cfg_emit_q};
      default:   prdata = '0;
    endcase
  end

  // effective values: zero acts as one, oversize clamps
  logic [SIDE_W-1:0] eff_side;
  logic [POOL_W-1:0] eff_pool;
  logic [ITER_W-1:0] eff_iters;
  logic [LCNT_W-1:0] eff_cells;

  always_comb begin
    eff_side  = (cfg_side_q == '0) ? SIDE_W'(1) :
                (cfg_side_q > SIDE_W'(MAX_SIDE)) ? SIDE_W'(MAX_SIDE) : cfg_side_q;
    eff_pool  = (cfg_pool_q == '0) ? POOL_W'(1) :
                (cfg_pool_q > POOL_W'(MAX_POOL)) ? POOL_W'(MAX_POOL) : cfg_pool_q;
    eff_iters = (cfg_iters_q == '0) ? ITER_W'(1) : cfg_iters_q;
    eff_cells = LCNT_W'(eff_side * eff_side);
  end

  // sequencer state
  state_e            state_q, state_d;
  logic [LCNT_W-1:0] lcnt_q, lcnt_d;
  logic [RCNT_W-1:0] rcnt_q, rcnt_d;
  logic [SIDE_W-1:0] side_q, side_d, np_q, np_d, bj_q, bj_d, bk_q, bk_d;
  logic [SIDE_W-1:0] row_q, row_d, col_q, col_d, rbase_q, rbase_d, cbase_q, cbase_d;
  logic [SIDE_W-1:0] lim_q, lim_d;
  logic [SIDE_W:0]   acc_q, acc_d;
  logic [POOL_W-1:0] pool_q, pool_d, a_q, a_d, b_q, b_d;
  logic [ITER_W-1:0] iters_q, iters_d, it_q, it_d;
  logic              emit_q, emit_d;
  logic [LCNT_W-1:0] cells_q, cells_d;
  logic [RCNT_W-1:0] total_q, total_d;
  logic [DEN_W-1:0]  den_q, den_d;
  logic [ADDR_W-1:0] pidx_q, pidx_d;
  logic [15:0]       ohold_q, ohold_d;
  logic              rd_pool_q, rd_pool_d;

  // memories
  logic [15:0]       orig_mem [CELLS];
  logic [31:0]       work_mem [CELLS];
  logic [15:0]       off_mem  [CELLS];
  logic [15:0]       orig_rdata, off_rdata;
  logic [31:0]       work_rdata;
  logic [ADDR_W-1:0] raddr, cell_addr, off_raddr;
  logic              orig_we, work_we, off_we;
  logic [31:0]       work_wdata;
  logic [15:0]       off_wdata;
  logic [RCNT_W-1:0] rsub;

  assign cell_addr = ADDR_W'(row_q * side_q + {{(ADDR_W-SIDE_W){1'b0}}, col_q});
  assign rsub      = rcnt_q - RCNT_W'(cells_q);
  assign off_raddr = rsub[ADDR_W-1:0];

  always_ff @(posedge clk_i) begin
    if (orig_we) begin
      orig_mem[lcnt_q[ADDR_W-1:0]] <= cmd_i.activation;
    end
    if (work_we) begin
      work_mem[cell_addr] <= work_wdata;
    end
    if (off_we) begin
      off_mem[pidx_q] <= off_wdata;
    end
    orig_rdata <= orig_mem[raddr];
    work_rdata <= work_mem[raddr];
    off_rdata  <= off_mem[off_raddr];
  end

  // shared units
  logic signed [32:0]  exp_x;
  logic [31:0]         exp_y;
  logic                div_start, div_done;
  logic [NUM_W-1:0]    div_num, div_quo;
  logic signed [22:0]  avg_sum;
  logic                pooled, cell_end, blk_end, last_blk;

  pmmf_exp u_exp (
    .clk_i (clk_i),
    .x_i   (exp_x),
    .y_o   (exp_y)
  );

  pmmf_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (den_q),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  always_comb begin
    pooled   = (row_q < lim_q) && (col_q < lim_q);
    cell_end = (col_q == side_q - 1'b1) && (row_q == side_q - 1'b1);
    blk_end  = (a_q == pool_q - 1'b1) && (b_q == pool_q - 1'b1);
    last_blk = (bj_q == np_q - 1'b1) && (bk_q == np_q - 1'b1);
    // first iteration reads the stored input scaled to q16.16
    if (it_q == '0) begin
      exp_x = 33'(signed'({orig_rdata, 6'd0}));
    end else if (pooled) begin
      exp_x = 33'(signed'(work_rdata));
    end else begin
      exp_x = signed'({1'b0, work_rdata});
    end
    // average of the probability with the original input
    avg_sum = signed'({6'd0, div_quo[16:0]}) + 23'(signed'({ohold_q, 6'd0}));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_LOAD;
      lcnt_q  <= '0;
      rcnt_q  <= '0;
      side_q  <= SIDE_W'(1);
      np_q    <= '0;
      emit_q  <= 1'b0;
      cells_q <= LCNT_W'(1);
      total_q <= RCNT_W'(1);
    end else begin
      state_q <= state_d;
      lcnt_q  <= lcnt_d;
      rcnt_q  <= rcnt_d;
      side_q  <= side_d;
      np_q    <= np_d;
      emit_q  <= emit_d;
      cells_q <= cells_d;
      total_q <= total_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bj_q      <= bj_d;
    bk_q      <= bk_d;
    row_q     <= row_d;
    col_q     <= col_d;
    rbase_q   <= rbase_d;
    cbase_q   <= cbase_d;
    lim_q     <= lim_d;
    acc_q     <= acc_d;
    pool_q    <= pool_d;
    a_q       <= a_d;
    b_q       <= b_d;
    iters_q   <= iters_d;
    it_q      <= it_d;
    den_q     <= den_d;
    pidx_q    <= pidx_d;
    ohold_q   <= ohold_d;
    rd_pool_q <= rd_pool_d;
  end

  always_comb begin
    state_d    = state_q;
    lcnt_d     = lcnt_q;
    rcnt_d     = rcnt_q;
    side_d     = side_q;
    np_d       = np_q;
    emit_d     = emit_q;
    cells_d    = cells_q;
    total_d    = total_q;
    bj_d       = bj_q;
    bk_d       = bk_q;
    row_d      = row_q;
    col_d      = col_q;
    rbase_d    = rbase_q;
    cbase_d    = cbase_q;
    lim_d      = lim_q;
    acc_d      = acc_q;
    pool_d     = pool_q;
    a_d        = a_q;
    b_d        = b_q;
    iters_d    = iters_q;
    it_d       = it_q;
    den_d      = den_q;
    pidx_d     = pidx_q;
    ohold_d    = ohold_q;
    rd_pool_d  = rd_pool_q;
    raddr      = cell_addr;
    orig_we    = 1'b0;
    work_we    = 1'b0;
    off_we     = 1'b0;
    work_wdata = exp_y;
    off_wdata  = (div_quo > NUM_W'(65535)) ? 16'hFFFF : div_quo[15:0];
    div_start  = 1'b0;
    div_num    = {work_rdata, 16'd0};
    busy       = 1'b1;
    result_valid_o   = 1'b0;
    result_o.value   = rd_pool_q ? off_rdata :
                       ((work_rdata > 32'd65535) ? 16'hFFFF : work_rdata[15:0]);
    result_o.is_pool = rd_pool_q;
    result_o.last    = (rcnt_q + 1'b1) >= total_q;

    case (state_q)
      S_LOAD: begin
        busy = 1'b0;
        if (start && cmd_i.command == CMD_LOAD) begin
          orig_we = (lcnt_q < LCNT_W'(CELLS));
          if ((lcnt_q + 1'b1) >= eff_cells) begin
            lcnt_d  = '0;
            side_d  = eff_side;
            pool_d  = eff_pool;
            iters_d = eff_iters;
            emit_d  = cfg_emit_q;
            np_d    = '0;
            acc_d   = (SIDE_W+1)'(eff_pool);
            state_d = S_PREP;
          end else begin
            lcnt_d = lcnt_q + 1'b1;
          end
        end
      end

      // block count per row by repeated add of the pool side
      S_PREP: begin
        if (acc_q <= {1'b0, side_q}) begin
          np_d  = np_q + 1'b1;
          acc_d = acc_q + (SIDE_W+1)'(pool_q);
        end else begin
          lim_d   = SIDE_W'(acc_q - (SIDE_W+1)'(pool_q));
          cells_d = LCNT_W'(side_q * side_q);
          total_d = RCNT_W'(side_q * side_q) +
                    (emit_q ? RCNT_W'(np_q * np_q) : RCNT_W'(0));
          it_d    = '0;
          row_d   = '0;
          col_d   = '0;
          state_d = S_EXP_RD;
        end
      end

      S_EXP_RD:  state_d = S_EXP_MUL;
      S_EXP_MUL: state_d = S_EXP_INT;
      S_EXP_INT: state_d = S_EXP_WR;

      S_EXP_WR: begin
        work_we = 1'b1;
        if (cell_end) begin
          if (np_q == '0) begin
            if (it_q == iters_q - 1'b1) begin
              rcnt_d  = '0;
              state_d = S_READ;
            end else begin
              it_d    = it_q + 1'b1;
              row_d   = '0;
              col_d   = '0;
              state_d = S_EXP_RD;
            end
          end else begin
            bj_d    = '0;
            bk_d    = '0;
            rbase_d = '0;
            cbase_d = '0;
            row_d   = '0;
            col_d   = '0;
            a_d     = '0;
            b_d     = '0;
            pidx_d  = '0;
            den_d   = DEN_W'(65536);
            state_d = S_SUM_RD;
          end
        end else if (col_q == side_q - 1'b1) begin
          col_d   = '0;
          row_d   = row_q + 1'b1;
          state_d = S_EXP_RD;
        end else begin
          col_d   = col_q + 1'b1;
          state_d = S_EXP_RD;
        end
      end

      S_SUM_RD: state_d = S_SUM_ACC;

      S_SUM_ACC: begin
        den_d = den_q + DEN_W'(work_rdata);
        if (blk_end) begin
          a_d     = '0;
          b_d     = '0;
          row_d   = rbase_q;
          col_d   = cbase_q;
          state_d = S_DIV_RD;
        end else begin
          if (b_q == pool_q - 1'b1) begin
            b_d   = '0;
            col_d = cbase_q;
            a_d   = a_q + 1'b1;
            row_d = row_q + 1'b1;
          end else begin
            b_d   = b_q + 1'b1;
            col_d = col_q + 1'b1;
          end
          state_d = S_SUM_RD;
        end
      end

      S_DIV_RD: state_d = S_DIV_ST;

      S_DIV_ST: begin
        div_start = 1'b1;
        ohold_d   = orig_rdata;
        state_d   = S_DIV_RUN;
      end

      S_DIV_RUN: begin
        if (div_done) begin
          state_d = S_DIV_WR;
        end
      end

      S_DIV_WR: begin
        work_we = 1'b1;
        if (it_q == iters_q - 1'b1) begin
          work_wdata = div_quo[31:0];
        end else begin
          work_wdata = {{10{avg_sum[22]}}, avg_sum[22:1]};
        end
        if (blk_end) begin
          if (it_q == iters_q - 1'b1) begin
            state_d = S_OFF_ST;
          end else begin
            state_d = S_OFF_WR;
          end
        end else begin
          if (b_q == pool_q - 1'b1) begin
            b_d   = '0;
            col_d = cbase_q;
            a_d   = a_q + 1'b1;
            row_d = row_q + 1'b1;
          end else begin
            b_d   = b_q + 1'b1;
            col_d = col_q + 1'b1;
          end
          state_d = S_DIV_RD;
        end
      end

      S_OFF_ST: begin
        div_start = 1'b1;
        div_num   = NUM_W'(64'h1_0000_0000);
        state_d   = S_OFF_RUN;
      end

      S_OFF_RUN: begin
        if (div_done) begin
          state_d = S_OFF_WR;
        end
      end

      // next block, or end of iteration; off value stored on the last one only
      S_OFF_WR: begin
        off_we = (it_q == iters_q - 1'b1);
        pidx_d = pidx_q + 1'b1;
        den_d  = DEN_W'(65536);
        a_d    = '0;
        b_d    = '0;
        if (last_blk) begin
          if (it_q == iters_q - 1'b1) begin
            rcnt_d  = '0;
            state_d = S_READ;
          end else begin
            it_d    = it_q + 1'b1;
            row_d   = '0;
            col_d   = '0;
            state_d = S_EXP_RD;
          end
        end else if (bk_q == np_q - 1'b1) begin
          bk_d    = '0;
          bj_d    = bj_q + 1'b1;
          cbase_d = '0;
          rbase_d = rbase_q + SIDE_W'(pool_q);
          row_d   = rbase_q + SIDE_W'(pool_q);
          col_d   = '0;
          state_d = S_SUM_RD;
        end else begin
          bk_d    = bk_q + 1'b1;
          cbase_d = cbase_q + SIDE_W'(pool_q);
          row_d   = rbase_q;
          col_d   = cbase_q + SIDE_W'(pool_q);
          state_d = S_SUM_RD;
        end
      end

      S_READ: begin
        busy  = 1'b0;
        raddr = rcnt_q[ADDR_W-1:0];
        if (start && cmd_i.command == CMD_READ) begin
          rd_pool_d = (rcnt_q >= RCNT_W'(cells_q));
          state_d   = S_RD_OUT;
        end
      end

      S_RD_OUT: begin
        result_valid_o = 1'b1;
        if ((rcnt_q + 1'b1) >= total_q) begin
          rcnt_d  = '0;
          state_d = S_LOAD;
        end else begin
          rcnt_d  = rcnt_q + 1'b1;
          state_d = S_READ;
        end
      end

      default: state_d = S_LOAD;
    endcase
  end

  // a result strobe only follows a read command, inside a busy cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni) result_valid_o |-> busy)
    else $error("result strobe outside busy");

  // every read returns to S_READ or S_LOAD after its strobe, so strobes never come back to back
  assert property (@(posedge clk_i) disable iff (!rst_ni) result_valid_o |=> !result_valid_o)
    else $error("back-to-back result strobes");

  // off probabilities appear only when the run latched emit on
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && result_o.is_pool) |-> emit_q)
    else $error("off probability without emit");

  // a final result ends the run and returns to loading
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && result_o.last) |=> (state_q == S_LOAD))
    else $error("run did not end after last result");

endmodule
